// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMPL(label, clk_s, rstn_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CHK_NEXT(label, clk_s, rstn_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/met_pkg.sv =====
package met_pkg;

  localparam int unsigned FRAC = 28;

  localparam logic [2:0] REG_X_LEFT      = 3'd0;
  localparam logic [2:0] REG_Y_TOP       = 3'd1;
  localparam logic [2:0] REG_X_RIGHT     = 3'd2;
  localparam logic [2:0] REG_IMAGE_WIDTH = 3'd3;
  localparam logic [2:0] REG_MAX_ITER    = 3'd4;

  localparam logic signed [31:0] X_LEFT_RST  = -32'sd671088640;
  localparam logic signed [31:0] Y_TOP_RST   = 32'sd402653184;
  localparam logic signed [31:0] X_RIGHT_RST = 32'sd268435456;
  localparam logic [10:0]        WIDTH_RST   = 11'd640;
  localparam logic [15:0]        ITER_RST    = 16'd256;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_STEP,
    CMD_MULC,
    CMD_CXY,
    CMD_PRE1,
    CMD_PRE2,
    CMD_PRE3,
    CMD_INIT,
    CMD_ITMUL,
    CMD_ITUPD,
    CMD_FIN_LIM,
    CMD_FIN_IT
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_STEP,
    S_MULC,
    S_CXY,
    S_PRE1,
    S_PRE2,
    S_PRE3,
    S_PRE4,
    S_ITM,
    S_ITA
  } state_t;

  typedef struct packed {
    logic div_done;
    logic set_hit;
    logic it_limit;
    logic escaped;
    logic fixed;
  } stat_t;

endpackage

// ===== src/met_div.sv =====
module met_div import met_pkg::*; #(
  parameter int DW = 11
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start_i,
  input  logic [32:0]   dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic          done_o,
  output logic [32:0]   quo_o,
  output logic          rem_nz_o
);

  localparam int NB = 33;
  localparam int CW = $clog2(NB + 1);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [32:0]   quo_r, quo_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] div_r, div_nxt;
  logic [DW:0]   rem_sh, rem_dif;
  logic          ge;

  always_comb begin
    rem_sh  = {rem_r, quo_r[32]};
    rem_dif = rem_sh - {1'b0, div_r};
    ge      = rem_sh >= {1'b0, div_r};
    cnt_nxt = cnt_r;
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    div_nxt = div_r;
    if (start_i) begin
      cnt_nxt = CW'(NB);
      quo_nxt = dividend_i;
      rem_nxt = '0;
      div_nxt = divisor_i;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - CW'(1);
      quo_nxt = {quo_r[31:0], ge};
      rem_nxt = ge ? rem_dif[DW-1:0] : rem_sh[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done_o   = (cnt_r == '0);
  assign quo_o    = quo_r;
  assign rem_nz_o = (rem_r != '0);

endmodule

// ===== src/met_dp.sv =====
`include "assert_macros.svh"

module met_dp import met_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic [9:0]  pixel_col,
  input  logic [9:0]  pixel_row,
  input  cmd_t        cmd_i,
  output stat_t       stat_o,
  output logic        strobe_o,
  output logic [15:0] count_o
);

  localparam int WW = $clog2(MAX_WIDTH + 1);

  localparam logic signed [31:0] CX_LO = -32'sd402653184;
  localparam logic signed [31:0] CX_HI = 32'sd134217728;
  localparam logic signed [31:0] CY_HI = 32'sd268435456;
  localparam logic signed [31:0] CY_LO = -32'sd268435456;

  function automatic logic [32:0] mag33(input logic [32:0] v);
    mag33 = v[32] ? (~v + 33'd1) : v;
  endfunction

  function automatic logic signed [31:0] sat44(input logic signed [43:0] v);
    if (v > 44'sd2147483647) begin
      sat44 = 32'sh7FFFFFFF;
    end else if (v < -44'sd2147483648) begin
      sat44 = 32'sh80000000;
    end else begin
      sat44 = v[31:0];
    end
  endfunction

  logic signed [31:0] x_left_r, y_top_r, x_right_r;
  logic [10:0]        image_width_r;
  logic [15:0]        max_iter_r;

  logic [9:0]         col_r, row_r;
  logic signed [31:0] step_r, step_nxt;
  logic signed [31:0] cx_r, cy_r;
  logic               region_r;
  logic [31:0]        q_r, qx_mag_r;
  logic               qx_neg_r;
  logic [35:0]        y2_r;
  logic               bulb_r;
  logic [32:0]        x_r, y_r;
  logic [15:0]        it_r;
  logic [63:0]        p0_r, p1_r, p2_r;
  logic               strobe_r;
  logic [15:0]        res_r;

  logic [32:0]   diff, diff_mag;
  logic [WW-1:0] w_sel;
  logic          div_done, rem_nz;
  logic [32:0]   quo;
  logic [33:0]   qm;

  always_comb begin
    diff     = {x_right_r[31], x_right_r} - {x_left_r[31], x_left_r};
    diff_mag = mag33(diff);
    if (image_width_r == '0) begin
      w_sel = WW'(1);
    end else if (32'(image_width_r) > 32'(MAX_WIDTH)) begin
      w_sel = WW'(MAX_WIDTH);
    end else begin
      w_sel = WW'(image_width_r);
    end
  end

  met_div #(.DW(WW)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start_i   (cmd_i == CMD_LOAD),
    .dividend_i(diff_mag),
    .divisor_i (w_sel),
    .done_o    (div_done),
    .quo_o     (quo),
    .rem_nz_o  (rem_nz)
  );

  always_comb begin
    qm = {1'b0, quo} + 34'(rem_nz);
    if (!diff[32]) begin
      step_nxt = (quo > 33'h07FFFFFFF) ? 32'sh7FFFFFFF : quo[31:0];
    end else begin
      step_nxt = (qm > 34'h080000000) ? 32'sh80000000 : (32'd0 - qm[31:0]);
    end
  end

  logic [31:0]        step_mag;
  logic signed [43:0] px_s, py_s, cx_w, cy_w;
  logic [32:0]        xq_w, cp1_w, xq_mag, cy_mag, cp1_mag;
  logic [35:0]        xq2, y2p, b2;
  logic [36:0]        q_w;
  logic [37:0]        qx_w, qx_m;
  logic [36:0]        bulb_sum;
  logic [32:0]        x_mag, y_mag;
  logic [35:0]        x2, y2i;
  logic [36:0]        esc_sum;
  logic [38:0]        xt_w;
  logic               dneg;
  logic [64:0]        dup;
  logic [37:0]        dmag;
  logic [39:0]        dv, yt_w;
  logic               card;

  always_comb begin
    step_mag = 32'(mag33({step_r[31], step_r}));
    px_s     = $signed({2'b00, p0_r[41:0]});
    py_s     = $signed({2'b00, p1_r[41:0]});
    if (step_r[31]) begin
      cx_w = $signed({{12{x_left_r[31]}}, x_left_r}) - px_s;
      cy_w = $signed({{12{y_top_r[31]}}, y_top_r}) + py_s;
    end else begin
      cx_w = $signed({{12{x_left_r[31]}}, x_left_r}) + px_s;
      cy_w = $signed({{12{y_top_r[31]}}, y_top_r}) - py_s;
    end

    xq_w    = {cx_r[31], cx_r} - 33'd67108864;
    cp1_w   = {cx_r[31], cx_r} + 33'd268435456;
    xq_mag  = mag33(xq_w);
    cy_mag  = mag33({cy_r[31], cy_r});
    cp1_mag = mag33(cp1_w);

    xq2      = p0_r[63:FRAC];
    y2p      = p1_r[63:FRAC];
    b2       = p2_r[63:FRAC];
    q_w      = {1'b0, xq2} + {1'b0, y2p};
    qx_w     = {1'b0, q_w} + {{5{xq_w[32]}}, xq_w};
    qx_m     = qx_w[37] ? (~qx_w + 38'd1) : qx_w;
    bulb_sum = {1'b0, b2} + {1'b0, y2p};
    card     = qx_neg_r || (p0_r[63:FRAC] <= {2'b00, y2_r[35:2]});

    x_mag   = mag33(x_r);
    y_mag   = mag33(y_r);
    x2      = p0_r[63:FRAC];
    y2i     = p1_r[63:FRAC];
    esc_sum = {1'b0, x2} + {1'b0, y2i};
    xt_w    = {3'b000, x2} - {3'b000, y2i} + {{7{cx_r[31]}}, cx_r};
    dneg    = (x_r[32] ^ y_r[32]) && (p2_r != '0);
    dup     = {1'b0, p2_r} + 65'h7FFFFFF;
    dmag    = dneg ? dup[64:27] : {1'b0, p2_r[63:27]};
    dv      = dneg ? (~{2'b00, dmag} + 40'd1) : {2'b00, dmag};
    yt_w    = dv + {{8{cy_r[31]}}, cy_r};
  end

  logic [31:0] ma0, mb0, ma1, mb1, ma2, mb2;

  always_comb begin
    ma0 = '0;
    mb0 = '0;
    ma1 = '0;
    mb1 = '0;
    ma2 = '0;
    mb2 = '0;
    unique case (cmd_i)
      CMD_MULC: begin
        ma0 = {22'd0, col_r};
        mb0 = step_mag;
        ma1 = {22'd0, row_r};
        mb1 = step_mag;
      end
      CMD_PRE1: begin
        ma0 = xq_mag[31:0];
        mb0 = xq_mag[31:0];
        ma1 = cy_mag[31:0];
        mb1 = cy_mag[31:0];
        ma2 = cp1_mag[31:0];
        mb2 = cp1_mag[31:0];
      end
      CMD_PRE3: begin
        ma0 = q_r;
        mb0 = qx_mag_r;
      end
      CMD_ITMUL: begin
        ma0 = x_mag[31:0];
        mb0 = x_mag[31:0];
        ma1 = y_mag[31:0];
        mb1 = y_mag[31:0];
        ma2 = x_mag[31:0];
        mb2 = y_mag[31:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_left_r      <= X_LEFT_RST;
      y_top_r       <= Y_TOP_RST;
      x_right_r     <= X_RIGHT_RST;
      image_width_r <= WIDTH_RST;
      max_iter_r    <= ITER_RST;
      strobe_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_X_LEFT:      x_left_r      <= cfg_data;
          REG_Y_TOP:       y_top_r       <= cfg_data;
          REG_X_RIGHT:     x_right_r     <= cfg_data;
          REG_IMAGE_WIDTH: image_width_r <= cfg_data[10:0];
          REG_MAX_ITER:    max_iter_r    <= cfg_data[15:0];
          default: begin
          end
        endcase
      end
      strobe_r <= (cmd_i == CMD_FIN_LIM) || (cmd_i == CMD_FIN_IT);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i == CMD_MULC || cmd_i == CMD_PRE1 || cmd_i == CMD_PRE3 ||
        cmd_i == CMD_ITMUL) begin
      p0_r <= ma0 * mb0;
      p1_r <= ma1 * mb1;
      p2_r <= ma2 * mb2;
    end
    case (cmd_i)
      CMD_LOAD: begin
        col_r <= pixel_col;
        row_r <= pixel_row;
      end
      CMD_STEP: step_r <= step_nxt;
      CMD_CXY: begin
        cx_r <= sat44(cx_w);
        cy_r <= sat44(cy_w);
      end
      CMD_PRE1: begin
        region_r <= (cx_r >= CX_LO) && (cx_r <= CX_HI) && (cy_r <= CY_HI) &&
                    (cy_r >= CY_LO);
      end
      CMD_PRE2: begin
        q_r      <= q_w[31:0];
        qx_neg_r <= qx_w[37];
        qx_mag_r <= qx_m[31:0];
        y2_r     <= y2p;
        bulb_r   <= bulb_sum <= 37'd16777216;
      end
      CMD_INIT: begin
        x_r  <= '0;
        y_r  <= '0;
        it_r <= '0;
      end
      CMD_ITUPD: begin
        x_r  <= xt_w[32:0];
        y_r  <= yt_w[32:0];
        it_r <= it_r + 16'd1;
      end
      CMD_FIN_LIM: res_r <= max_iter_r;
      CMD_FIN_IT:  res_r <= it_r;
      default: begin
      end
    endcase
  end

  always_comb begin
    stat_o.div_done = div_done;
    stat_o.set_hit  = region_r && (card || bulb_r);
    stat_o.it_limit = it_r >= max_iter_r;
    stat_o.escaped  = esc_sum > 37'h040000000;
    stat_o.fixed    = (xt_w[32:0] == x_r) && (yt_w[32:0] == y_r);
  end

  assign strobe_o = strobe_r;
  assign count_o  = res_r;

  `CHK_IMPL(a_count_le_limit, clk, rst_n, strobe_o, count_o <= max_iter_r, "count above limit")
  `CHK_IMPL(a_upd_below_limit, clk, rst_n, cmd_i == CMD_ITUPD, it_r < max_iter_r, "update at limit")

endmodule

// ===== src/met_ctrl.sv =====
module met_ctrl import met_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o,
  output logic  busy_o
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd_o     = CMD_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (start_i) begin
          cmd_o     = CMD_LOAD;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        cmd_o     = CMD_STEP;
        state_nxt = S_MULC;
      end
      S_MULC: begin
        cmd_o     = CMD_MULC;
        state_nxt = S_CXY;
      end
      S_CXY: begin
        cmd_o     = CMD_CXY;
        state_nxt = S_PRE1;
      end
      S_PRE1: begin
        cmd_o     = CMD_PRE1;
        state_nxt = S_PRE2;
      end
      S_PRE2: begin
        cmd_o     = CMD_PRE2;
        state_nxt = S_PRE3;
      end
      S_PRE3: begin
        cmd_o     = CMD_PRE3;
        state_nxt = S_PRE4;
      end
      S_PRE4: begin
        if (stat_i.set_hit) begin
          cmd_o     = CMD_FIN_LIM;
          state_nxt = S_IDLE;
        end else begin
          cmd_o     = CMD_INIT;
          state_nxt = S_ITM;
        end
      end
      S_ITM: begin
        if (stat_i.it_limit) begin
          cmd_o     = CMD_FIN_IT;
          state_nxt = S_IDLE;
        end else begin
          cmd_o     = CMD_ITMUL;
          state_nxt = S_ITA;
        end
      end
      S_ITA: begin
        if (stat_i.escaped) begin
          cmd_o     = CMD_FIN_IT;
          state_nxt = S_IDLE;
        end else if (stat_i.fixed) begin
          cmd_o     = CMD_FIN_LIM;
          state_nxt = S_IDLE;
        end else begin
          cmd_o     = CMD_ITUPD;
          state_nxt = S_ITM;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_r != S_IDLE);

endmodule

// ===== src/mandelbrot_escape_time.sv =====
// Sequence: a request starts the step divider; then come the step, the pixel offsets, the point and the
//   cardioid and bulb test. A point caught by the test ends there; any other point runs the iteration
//   loop, a multiply state and an update state per iteration, until it escapes, stops moving or hits the limit.
// Throughput: one request at a time; busy stays high until the result is issued.
// Reset: synchronous, active low; the configuration registers return to their defaults, the controller to idle.
// Results are strobed for one cycle; the receiver cannot stall.
`include "assert_macros.svh"

module mandelbrot_escape_time import met_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [9:0]  in_pixel_col,
  input  logic [9:0]  in_pixel_row,
  output logic        out_strobe,
  output logic [15:0] out_iter_count,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  met_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start_i(start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  met_dp #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .pixel_col(in_pixel_col),
    .pixel_row(in_pixel_row),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .strobe_o (out_strobe),
    .count_o  (out_iter_count)
  );

  `CHK_NEXT(a_busy_after_start, clk, rst_n, start && !busy, busy, "request not taken")
  `CHK_IMPL(a_strobe_from_busy, clk, rst_n, out_strobe, $past(busy), "result without request")
  `CHK_NEXT(a_strobe_single, clk, rst_n, out_strobe, !out_strobe, "result repeated")

endmodule

// ===== sim/mandelbrot_escape_time_tb.sv =====
`timescale 1ns / 100ps

module mandelbrot_escape_time_tb;
  import met_pkg::*;

  localparam int          MAX_W       = 1024;
  localparam longint      ONE_Q       = longint'(1) << FRAC;
  localparam int          CYCLE_LIMIT = 4000000;
  localparam logic [31:0] Q_MIN       = 32'h8000_0000;
  localparam logic [31:0] Q_MAX       = 32'h7fff_ffff;

  class escape_ledger;
    longint      left_edge, top_edge, right_edge;
    logic [10:0] line_width;
    logic [15:0] iter_limit;
    logic [15:0] expected_counts[$];
    int          requests, results, mismatches, held;

    function new();
      left_edge  = longint'(X_LEFT_RST);
      top_edge   = longint'(Y_TOP_RST);
      right_edge = longint'(X_RIGHT_RST);
      line_width = WIDTH_RST;
      iter_limit = ITER_RST;
      requests   = 0;
      results    = 0;
      mismatches = 0;
      held       = 0;
    endfunction

    function void set_reg(logic [2:0] index, logic [31:0] data);
      case (index)
        REG_X_LEFT:      left_edge  = longint'($signed(data));
        REG_Y_TOP:       top_edge   = longint'($signed(data));
        REG_X_RIGHT:     right_edge = longint'($signed(data));
        REG_IMAGE_WIDTH: line_width = data[10:0];
        REG_MAX_ITER:    iter_limit = data[15:0];
        default: ;
      endcase
    endfunction

    function longint pixels_per_line();
      if (line_width == 0) return 1;
      if (line_width > MAX_W) return longint'(MAX_W);
      return longint'(line_width);
    endfunction

    function longint unsigned magnitude(longint v);
      longint unsigned m;
      m = v;
      if (v < 0) m = -m;
      return m;
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint unsigned square_q28(longint v);
      longint unsigned m;
      m = magnitude(v);
      return (m * m) >> FRAC;
    endfunction

    // round toward minus infinity after doubling
    function longint twice_product_q28(longint a, longint b);
      longint unsigned p;
      p = magnitude(a) * magnitude(b);
      if (((a < 0) != (b < 0)) && p != 0) return -longint'((p + 64'd134217727) >> 27);
      return longint'(p >> 27);
    endfunction

    function bit in_cardioid_or_bulb(longint cx, longint cy);
      longint xq, y2, q, lhs;
      if (cx < -(ONE_Q + ONE_Q / 2) || cx > ONE_Q / 2 || cy > ONE_Q || cy < -ONE_Q) return 0;
      xq  = cx - ONE_Q / 4;
      y2  = longint'(square_q28(cy));
      q   = longint'(square_q28(xq)) + y2;
      lhs = (q * (q + xq)) >>> FRAC;
      if (lhs <= (y2 >>> 2)) return 1;
      return (longint'(square_q28(cx + ONE_Q)) + y2) <= (ONE_Q >>> 4);
    endfunction

    function logic [15:0] escape_count(longint cx, longint cy, logic [15:0] limit);
      longint          x, y, xt, yt;
      longint unsigned x2, y2;
      int unsigned     n;
      x = 0;
      y = 0;
      if (in_cardioid_or_bulb(cx, cy)) return limit;
      for (n = 0; n < limit; n++) begin
        x2 = square_q28(x);
        y2 = square_q28(y);
        if (x2 + y2 > (64'd4 << FRAC)) return 16'(n);
        xt = longint'(x2) - longint'(y2) + cx;
        yt = twice_product_q28(x, y) + cy;
        if (xt == x && yt == y) return limit;
        x = xt;
        y = yt;
      end
      return limit;
    endfunction

    function logic [15:0] predict_escape_count(logic [9:0] col, logic [9:0] row);
      longint w, d, step, cx, cy;
      w = pixels_per_line();
      d = right_edge - left_edge;
      step = d / w;
      if ((d % w) != 0 && d < 0) step = step - 1;
      step = clamp32(step);
      cx = clamp32(left_edge + longint'(col) * step);
      cy = clamp32(top_edge - longint'(row) * step);
      return escape_count(cx, cy, iter_limit);
    endfunction

    function void note_request(logic [9:0] col, logic [9:0] row);
      logic [15:0] want;
      want = predict_escape_count(col, row);
      if (want == iter_limit) held++;
      requests++;
      expected_counts.push_back(want);
    endfunction

    function void check_result(logic [15:0] got);
      logic [15:0] want;
      results++;
      if (expected_counts.size() == 0) begin
        $display("%0t: iteration count with no request pending, expected none, got %0d",
                 $time, got);
        mismatches++;
        return;
      end
      want = expected_counts.pop_front();
      if (got !== want) begin
        $display("%0t: iteration count mismatch, expected %0d, got %0d", $time, want, got);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_counts.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [9:0]  in_pixel_col = '0;
  logic [9:0]  in_pixel_row = '0;
  logic        out_strobe;
  logic [15:0] out_iter_count;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = REG_X_LEFT;
  logic [31:0] cfg_data = '0;

  escape_ledger ledger;
  int           idle_pct = 0;
  int           views = 0;
  int           cycle_count = 0;

  mandelbrot_escape_time #(.MAX_WIDTH(MAX_W)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_pixel_col(in_pixel_col),
    .in_pixel_row(in_pixel_row),
    .out_strobe(out_strobe),
    .out_iter_count(out_iter_count),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && start && !busy) ledger.note_request(in_pixel_col, in_pixel_row);
    if (rst_n && out_strobe) ledger.check_result(out_iter_count);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycle_count, ledger.pending());
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic longint jitter(longint reach);
    return longint'($urandom_range(32'(2 * reach))) - reach;
  endfunction

  task automatic write_reg(input logic [2:0] index, input logic [31:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = index;
    cfg_data = data;
    ledger.set_reg(index, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // hold off until every pending count has come back
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (ledger.pending() != 0 || busy) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic set_view(input logic [31:0] lft, top, rgt, input logic [10:0] w,
                          input logic [15:0] lim);
    logic [31:0] w_data, lim_data;
    w_data = $urandom;
    w_data[10:0] = w;
    lim_data = $urandom;
    lim_data[15:0] = lim;
    drain();
    write_reg(REG_X_LEFT, lft);
    write_reg(REG_Y_TOP, top);
    write_reg(REG_X_RIGHT, rgt);
    write_reg(REG_IMAGE_WIDTH, w_data);
    write_reg(REG_MAX_ITER, lim_data);
    views++;
  endtask

  task automatic send_request(input logic [9:0] col, input logic [9:0] row);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    in_pixel_col = col;
    in_pixel_row = row;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic send_random_pixel();
    int         w, h;
    logic [9:0] col, row;
    w = int'(ledger.pixels_per_line());
    h = w / 4 * 3;
    if ($urandom_range(9) == 0) begin
      col = 10'($urandom_range(1023));
      row = 10'($urandom_range(1023));
    end else begin
      col = 10'($urandom_range(w - 1));
      row = (h > 0) ? 10'($urandom_range(h - 1)) : 10'd0;
    end
    send_request(col, row);
  endtask

  task automatic set_random_view();
    longint      re, im, span;
    logic [31:0] lft, top, rgt;
    logic [10:0] w;
    logic [15:0] lim;
    int          kind;
    kind = $urandom_range(9);
    w = 11'($urandom_range(1, MAX_W));
    if ($urandom_range(7) == 0) begin
      w = ($urandom_range(1) == 0) ? 11'd0 : 11'($urandom_range(MAX_W + 1, 2047));
    end
    lim = ($urandom_range(4) == 0) ? 16'd256 : 16'($urandom_range(1, 160));
    case ($urandom_range(6))
      0:       begin re = -3 * ONE_Q / 4;           im = ONE_Q / 10;      end
      1:       begin re = ONE_Q / 4 + ONE_Q / 32;   im = ONE_Q / 64;      end
      2:       begin re = -5 * ONE_Q / 4;           im = 0;               end
      3:       begin re = -ONE_Q / 8;               im = 3 * ONE_Q / 4;   end
      4:       begin re = -7 * ONE_Q / 4;           im = ONE_Q / 50;      end
      5:       begin re = 9 * ONE_Q / 25;           im = 8 * ONE_Q / 25;  end
      default: begin re = -ONE_Q / 2;               im = 14 * ONE_Q / 25; end
    endcase
    span = ONE_Q >>> $urandom_range(2, 12);
    re = re + jitter(span / 2);
    im = im + jitter(span / 2);
    if (kind < 4) begin
      lft = 32'(-5 * ONE_Q / 2 + jitter(ONE_Q / 4));
      rgt = 32'(ONE_Q + jitter(ONE_Q / 4));
      top = 32'(3 * ONE_Q / 2 + jitter(ONE_Q / 4));
    end else if (kind < 8) begin
      lft = 32'(re - span);
      rgt = 32'(re + span);
      top = 32'(im + span * 3 / 4);
    end else if (kind == 8) begin
      lft = $urandom;
      rgt = $urandom;
      top = $urandom;
    end else begin
      lft = 32'(re + span);
      rgt = 32'(re - span);
      top = 32'(im - span / 2);
    end
    set_view(lft, top, rgt, w, lim);
  endtask

  initial begin
    int phase, k;
    ledger = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset view, corners and points outside the image
    send_request(10'd0, 10'd0);
    send_request(10'd1023, 10'd1023);
    send_request(10'd320, 10'd240);
    send_request(10'd480, 10'd240);

    // bulb, cardioid and fast escape at the top limit; saturated column
    set_view(32'(-ONE_Q), 32'd0, 32'(ONE_Q), 11'd2, 16'hffff);
    send_request(10'd0, 10'd0);
    send_request(10'd1, 10'd0);
    send_request(10'd2, 10'd0);
    send_request(10'd1023, 10'd0);

    // zero limit
    set_view(X_LEFT_RST, Y_TOP_RST, X_RIGHT_RST, WIDTH_RST, 16'd0);
    send_request(10'd320, 10'd240);
    send_request(10'd0, 10'd0);

    // coordinate extremes, zero width, saturated step
    set_view(Q_MIN, Q_MAX, Q_MAX, 11'd0, 16'd1);
    send_request(10'd0, 10'd0);
    send_request(10'd1023, 10'd1023);
    send_request(10'd1, 10'd1);

    // right edge left of left edge, inexact step, width past the maximum
    set_view(32'(ONE_Q / 2), 32'(-ONE_Q), 32'(-(3 * ONE_Q / 2) - 1), 11'd2047, 16'd48);
    send_request(10'd0, 10'd0);
    send_request(10'd256, 10'd0);
    send_request(10'd768, 10'd512);
    send_request(10'd1023, 10'd1023);

    // corners of the cardioid and bulb test region
    set_view(32'(-(3 * ONE_Q / 2)), 32'(ONE_Q), 32'(ONE_Q / 2), 11'd1, 16'd40);
    send_request(10'd0, 10'd0);
    send_request(10'd1, 10'd0);
    send_request(10'd0, 10'd1);
    send_request(10'd1, 10'd1);

    // cardioid cusp
    set_view(32'(ONE_Q / 4), 32'd0, 32'(ONE_Q / 4), 11'd1024, 16'd100);
    send_request(10'd0, 10'd0);

    for (phase = 0; phase < 16; phase++) begin
      idle_pct = (phase % 3 == 0) ? 0 : (phase % 3 == 1) ? 47 : 29;
      set_random_view();
      for (k = 0; k < 53; k++) begin
        if ($urandom_range(39) == 0) drain();
        send_random_pixel();
      end
    end

    drain();
    repeat (60) @(posedge clk);
    $display("Checked %0d iteration counts from %0d pixel requests under %0d register settings",
             ledger.results, ledger.requests, views + 1);
    $display("%0d points ran to the iteration limit, %0d escaped before it",
             ledger.held, ledger.requests - ledger.held);
    if (ledger.mismatches == 0 && ledger.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
